>>> src/bwtlf_pkg.sv
// shared types and constants for the inverse bwt lf-mapping core
// no dependencies
package bwtlf_pkg;

  // symbol alphabet and fixed field widths
  localparam int unsigned SymCount = 256;
  localparam int unsigned SymW     = 8;
  localparam int unsigned PrimW    = 12;
  localparam int unsigned PosW     = 12;

  // result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_BLOCK    = 2'd1;
  localparam logic [1:0] ST_BAD_PRIMARY = 2'd2;
  localparam logic [1:0] ST_OVERFLOW    = 2'd3;

  // count table access from the sequencer
  typedef struct packed {
    logic            rd;
    logic            wr;
    logic            clr;
    logic [SymW-1:0] addr;
  } cnt_ctrl_t;

endpackage

>>> src/bwtlf_count_table.sv
// per-symbol count table: 256-entry memory with registered read and valid bits
// depends on bwtlf_pkg
module bwtlf_count_table #(
  parameter int unsigned CntW = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bwtlf_pkg::cnt_ctrl_t ctrl_i,
  input  logic [CntW-1:0]     wdata_i,
  output logic [CntW-1:0]     rdata_o
);
  import bwtlf_pkg::*;

  logic [CntW-1:0]     mem_q [SymCount];
  logic [CntW-1:0]     rdata_q;
  logic [SymCount-1:0] vld_q;
  logic                rvld_q;

  // storage array, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem_q[ctrl_i.addr] <= wdata_i;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem_q[ctrl_i.addr];
    end
  end

  // valid bits, cleared together at reset and at block end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        vld_q <= '0;
      end else if (ctrl_i.wr) begin
        vld_q[ctrl_i.addr] <= 1'b1;
      end
      if (ctrl_i.rd) begin
        rvld_q <= vld_q[ctrl_i.addr];
      end
    end
  end

  // entries never written since the last clear read as zero
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

>>> src/bwtlf_row_store.sv
// row store: symbol and occurrence rank per last-column row
// single-port memory with registered read, no dependencies
module bwtlf_row_store #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12,
  parameter int unsigned DataW = 20
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bwt_inverse_lf_mapping_core.sv
// top level of the inverse bwt core: sequencer, shared adder, stores
// depends on bwtlf_pkg, bwtlf_count_table, bwtlf_row_store
//
//  channel   direction  handshake                 payload
//  command   in         start_i high, busy_o low  kind_i symbol_i last_symbol_i
//                                                 primary_index_i
//  result    out        out_valid_o, one cycle    out_byte_o position_o
//                                                 final_byte_o status_o
//
// a load word passes through accept, count read, and count and row write; the
// last load adds a check step and a prefix sweep, a count read and a write per
// symbol value through the count table port and the shared adder.
// a request word passes through row read, count read, lf add.
// the result strobe rises as busy_o falls, so a new word can be taken while
// a result is shown; the receiver cannot stall. reset clears the count table
// valid bits at once, there is no clearing pass.
module bwt_inverse_lf_mapping_core #(
  parameter int unsigned BLOCK_SIZE = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          kind_i,
  input  logic [bwtlf_pkg::SymW-1:0]    symbol_i,
  input  logic                          last_symbol_i,
  input  logic [bwtlf_pkg::PrimW-1:0]   primary_index_i,
  output logic                          out_valid_o,
  output logic [bwtlf_pkg::SymW-1:0]    out_byte_o,
  output logic [bwtlf_pkg::PosW-1:0]    position_o,
  output logic                          final_byte_o,
  output logic [1:0]                    status_o
);
  import bwtlf_pkg::*;

  localparam int unsigned AddrW = $clog2(BLOCK_SIZE);
  localparam int unsigned LenW  = $clog2(BLOCK_SIZE + 1);
  localparam int unsigned SumW  = LenW + 1;
  localparam int unsigned CmpW  = (LenW > PrimW) ? LenW : PrimW;
  localparam int unsigned RowW  = SymW + AddrW;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LD_RD  = 4'd1;
  localparam logic [3:0] S_LD_WR  = 4'd2;
  localparam logic [3:0] S_LD_CHK = 4'd3;
  localparam logic [3:0] S_PF_RD  = 4'd4;
  localparam logic [3:0] S_PF_WR  = 4'd5;
  localparam logic [3:0] S_DC_ROW = 4'd6;
  localparam logic [3:0] S_DC_CNT = 4'd7;
  localparam logic [3:0] S_DC_OUT = 4'd8;

  // block phase
  localparam logic PH_LOAD   = 1'b0;
  localparam logic PH_DECODE = 1'b1;

  logic [3:0]       state_q, state_d;
  logic             phase_q, phase_d;
  logic [SymW-1:0]  sym_q, sym_d;
  logic             last_q, last_d;
  logic [PrimW-1:0] prim_q, prim_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [AddrW-1:0] cursor_q, cursor_d;
  logic             ovf_q, ovf_d;
  logic [SymW-1:0]  idx_q, idx_d;
  logic [LenW-1:0]  sum_q, sum_d;

  logic             res_vld_q, res_vld_d;
  logic [SymW-1:0]  res_byte_q, res_byte_d;
  logic [PosW-1:0]  res_pos_q, res_pos_d;
  logic             res_fin_q, res_fin_d;
  logic [1:0]       res_st_q, res_st_d;

  cnt_ctrl_t        cnt_ctrl;
  logic [LenW-1:0]  cnt_wdata;
  logic [LenW-1:0]  cnt_rdata;

  logic             row_we;
  logic             row_re;
  logic [AddrW-1:0] row_addr;
  logic [RowW-1:0]  row_wdata;
  logic [RowW-1:0]  row_rdata;
  logic [SymW-1:0]  row_sym;
  logic [AddrW-1:0] row_occ;

  logic [SumW-1:0]  add_a;
  logic [SumW-1:0]  add_b;
  logic [SumW-1:0]  add_y;
  logic [LenW-1:0]  rem_m1;
  logic             blk_clr;

  bwtlf_count_table #(
    .CntW (LenW)
  ) u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cnt_ctrl),
    .wdata_i (cnt_wdata),
    .rdata_o (cnt_rdata)
  );

  bwtlf_row_store #(
    .Depth (BLOCK_SIZE),
    .AddrW (AddrW),
    .DataW (RowW)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .re_i    (row_re),
    .addr_i  (row_addr),
    .wdata_i (row_wdata),
    .rdata_o (row_rdata)
  );

  assign row_sym = row_rdata[RowW-1:AddrW];
  assign row_occ = row_rdata[AddrW-1:0];
  assign rem_m1  = rem_q - LenW'(1);

  // shared adder: rank increment, prefix sum, lf step
  always_comb begin
    add_a = '0;
    add_b = '0;
    unique case (state_q)
      S_LD_WR: begin
        add_a = SumW'(cnt_rdata);
        add_b = SumW'(1);
      end
      S_PF_WR: begin
        add_a = SumW'(sum_q);
        add_b = SumW'(cnt_rdata);
      end
      S_DC_OUT: begin
        add_a = SumW'(cnt_rdata);
        add_b = SumW'(row_occ);
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_y = add_a + add_b;

  // sequencer
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    sym_d      = sym_q;
    last_d     = last_q;
    prim_d     = prim_q;
    len_d      = len_q;
    rem_d      = rem_q;
    cursor_d   = cursor_q;
    ovf_d      = ovf_q;
    idx_d      = idx_q;
    sum_d      = sum_q;
    res_vld_d  = 1'b0;
    res_byte_d = '0;
    res_pos_d  = '0;
    res_fin_d  = 1'b0;
    res_st_d   = ST_OK;
    cnt_ctrl   = '0;
    cnt_wdata  = add_y[LenW-1:0];
    row_we     = 1'b0;
    row_re     = 1'b0;
    row_addr   = cursor_q;
    row_wdata  = {sym_q, cnt_rdata[AddrW-1:0]};
    blk_clr    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          sym_d  = symbol_i;
          last_d = last_symbol_i;
          prim_d = primary_index_i;
          if (!kind_i) begin
            // a load abandons any block still being decoded
            if (phase_q == PH_DECODE) begin
              blk_clr = 1'b1;
            end
            state_d = S_LD_RD;
          end else if (phase_q != PH_DECODE || rem_q == '0) begin
            res_vld_d = 1'b1;
            res_st_d  = ST_NO_BLOCK;
          end else begin
            state_d = S_DC_ROW;
          end
        end
      end
      S_LD_RD: begin
        cnt_ctrl.rd   = 1'b1;
        cnt_ctrl.addr = sym_q;
        state_d       = S_LD_WR;
      end
      S_LD_WR: begin
        cnt_ctrl.addr = sym_q;
        if (len_q < LenW'(BLOCK_SIZE)) begin
          cnt_ctrl.wr = 1'b1;
          row_we      = 1'b1;
          row_addr    = len_q[AddrW-1:0];
          len_d       = len_q + LenW'(1);
        end else begin
          ovf_d = 1'b1;
        end
        state_d = last_q ? S_LD_CHK : S_IDLE;
      end
      S_LD_CHK: begin
        priority if (ovf_q) begin
          res_vld_d = 1'b1;
          res_st_d  = ST_OVERFLOW;
          blk_clr   = 1'b1;
          state_d   = S_IDLE;
        end else if (CmpW'(prim_q) >= CmpW'(len_q)) begin
          res_vld_d = 1'b1;
          res_st_d  = ST_BAD_PRIMARY;
          blk_clr   = 1'b1;
          state_d   = S_IDLE;
        end else begin
          idx_d   = '0;
          sum_d   = '0;
          state_d = S_PF_RD;
        end
      end
      S_PF_RD: begin
        cnt_ctrl.rd   = 1'b1;
        cnt_ctrl.addr = idx_q;
        state_d       = S_PF_WR;
      end
      S_PF_WR: begin
        // exclusive prefix: store running sum, then add this count
        cnt_ctrl.wr   = 1'b1;
        cnt_ctrl.addr = idx_q;
        cnt_wdata     = sum_q;
        sum_d         = add_y[LenW-1:0];
        idx_d         = idx_q + SymW'(1);
        if (idx_q == SymW'(SymCount - 1)) begin
          cursor_d  = AddrW'(prim_q);
          rem_d     = len_q;
          phase_d   = PH_DECODE;
          res_vld_d = 1'b1;
          res_st_d  = ST_OK;
          state_d   = S_IDLE;
        end else begin
          state_d = S_PF_RD;
        end
      end
      S_DC_ROW: begin
        row_re  = 1'b1;
        state_d = S_DC_CNT;
      end
      S_DC_CNT: begin
        cnt_ctrl.rd   = 1'b1;
        cnt_ctrl.addr = row_sym;
        state_d       = S_DC_OUT;
      end
      S_DC_OUT: begin
        // next row = count[byte] + rank, out-of-range rows fall back to zero
        cursor_d   = (add_y < SumW'(BLOCK_SIZE)) ? add_y[AddrW-1:0] : '0;
        rem_d      = rem_m1;
        res_vld_d  = 1'b1;
        res_byte_d = row_sym;
        res_pos_d  = PosW'(rem_m1);
        res_fin_d  = (rem_m1 == '0);
        res_st_d   = ST_OK;
        if (rem_m1 == '0) begin
          blk_clr = 1'b1;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // block clear: counts, length, remaining, cursor, overflow, back to loading
    if (blk_clr) begin
      cnt_ctrl.clr = 1'b1;
      len_d        = '0;
      rem_d        = '0;
      cursor_d     = '0;
      ovf_d        = 1'b0;
      phase_d      = PH_LOAD;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_LOAD;
      len_q     <= '0;
      rem_q     <= '0;
      cursor_q  <= '0;
      ovf_q     <= 1'b0;
      idx_q     <= '0;
      sum_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      len_q     <= len_d;
      rem_q     <= rem_d;
      cursor_q  <= cursor_d;
      ovf_q     <= ovf_d;
      idx_q     <= idx_d;
      sum_q     <= sum_d;
      res_vld_q <= res_vld_d;
    end
  end

  // captured word and result payload
  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    last_q     <= last_d;
    prim_q     <= prim_d;
    res_byte_q <= res_byte_d;
    res_pos_q  <= res_pos_d;
    res_fin_q  <= res_fin_d;
    res_st_q   <= res_st_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign out_valid_o  = res_vld_q;
  assign out_byte_o   = res_byte_q;
  assign position_o   = res_pos_q;
  assign final_byte_o = res_fin_q;
  assign status_o     = res_st_q;

`ifndef SYNTH
  // final byte only comes with an ok status
  a_final_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && final_byte_o) |-> (status_o == ST_OK))
    else $error("final byte with error status");

  // status-only results carry zero byte and position
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (out_byte_o == '0 && position_o == '0))
    else $error("status result with nonzero payload");

  // an accepted load word keeps the core busy for the next cycle
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !kind_i) |=> busy_o)
    else $error("load word did not start the sequencer");

  // a decoding block always has bytes left
  a_decode_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DECODE) |-> (rem_q != '0))
    else $error("decode phase with no bytes remaining");
`endif

endmodule
